FILE: hdl/three_body_gravity_step_unit_assert.svh
// Assertion macros for the three-body gravity step unit.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef THREE_BODY_GRAVITY_STEP_UNIT_ASSERT_SVH
`define THREE_BODY_GRAVITY_STEP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TBG_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbg assertion failed");

// Next-cycle implication, checked outside reset.
`define TBG_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbg assertion failed");

`endif

FILE: hdl/tbg_pkg.sv
// Package of the three-body gravity step unit: types, scene constants and helpers.
// Has no dependencies.
`default_nettype none

package tbg_pkg;

    localparam int NUM_BODIES = 3;
    localparam int IDX_W      = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
    localparam int ACC_W      = 52;

    localparam logic [31:0] G_RESET = 32'h0014_0000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic        [31:0] m;
    } body_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
    } acc_t;

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_RDI    = 21'h000002,
        S_RDJ    = 21'h000004,
        S_DIFF   = 21'h000008,
        S_SQX    = 21'h000010,
        S_SQY    = 21'h000020,
        S_D2     = 21'h000040,
        S_SQRT   = 21'h000080,
        S_MM     = 21'h000100,
        S_GM     = 21'h000200,
        S_QST    = 21'h000400,
        S_DIV    = 21'h000800,
        S_DIVEND = 21'h001000,
        S_MULA   = 21'h002000,
        S_RST    = 21'h004000,
        S_ACCRI  = 21'h008000,
        S_ACCWI  = 21'h010000,
        S_ACCWJ  = 21'h020000,
        S_NEXT   = 21'h040000,
        S_URD    = 21'h080000,
        S_UWR    = 21'h100000
    } state_t;

    typedef enum logic [2:0] {
        DOP_Q  = 3'b001,
        DOP_R  = 3'b010,
        DOP_DV = 3'b100
    } div_op_t;

    // Default scene; bodies past the third start at zero.
    function automatic body_t scene_body(input logic [IDX_W-1:0] idx);
        body_t b;
        b = '0;
        if (int'(idx) == 0)
        begin
            b.px = 32'sh01E0_0000;
            b.py = 32'sh0168_0000;
            b.vx = 32'shFFFF_8000;
            b.m  = 32'h0001_0000;
        end
        else if (int'(idx) == 1)
        begin
            b.px = 32'sh02D0_0000;
            b.py = 32'sh01E0_0000;
            b.m  = 32'h0005_0000;
        end
        else if (int'(idx) == 2)
        begin
            b.px = 32'sh0078_0000;
            b.py = 32'sh00F0_0000;
            b.m  = 32'h0002_0000;
        end
        return b;
    endfunction

    // Magnitude of a coordinate difference, clipped to 2^31-1.
    function automatic logic [30:0] mag31(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        if (|m[32:31])
        begin
            return 31'h7FFF_FFFF;
        end
        return m[30:0];
    endfunction

    // Drop 16 fraction bits of a product and clip to 32 bits.
    function automatic logic [31:0] cap_q16(input logic [63:0] p);
        if (|p[63:48])
        begin
            return 32'hFFFF_FFFF;
        end
        return p[47:16];
    endfunction

    // Clip a velocity sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat_vel(input logic signed [ACC_W:0] v);
        if (!v[ACC_W] && (|v[ACC_W-1:31]))
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v[ACC_W] && !(&v[ACC_W-1:31]))
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Clip a position sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat_pos(input logic signed [32:0] v);
        if (v[32] != v[31])
        begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/three_body_gravity_step_unit.sv
// Three-body gravity step unit: keeps the bodies in a small memory and advances them.
// Depends on tbg_pkg and three_body_gravity_step_unit_assert.svh.
// A load word is written to the body memory as it is accepted. A tick works through each body
// pair with a bit-serial square root and a bit-serial divider for five divisions, skips those on
// a coincident pair, then updates each body; one tick at a time, no input is taken until it ends.
// Reset: bodies read as the default scene and G as 20.0 until written; no clearing pass.
`default_nettype none

module three_body_gravity_step_unit
    import tbg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // body_index[1:0], load_pos_x, load_pos_y, load_vel_x, load_vel_y, load_mass, zero pad
    input  wire logic [167:0] s_axis_tdata,
    // mode
    input  wire logic [0:0]   s_axis_tuser,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_index[1:0], out_pos_x, out_pos_y, out_vel_x, out_vel_y, zero pad
    output      logic [135:0] m_axis_tdata,
    // coincident
    output      logic [0:0]   m_axis_tuser,
    output      logic         m_axis_tlast,
    input  wire logic         cfg_valid,
    output      logic         cfg_ready,
    input  wire logic [31:0]  cfg_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BODIES - 1);

    state_t state_reg, state_next;

    logic [31:0]            g_reg;
    logic [IDX_W-1:0]       pi_reg, pj_reg, pb_reg;
    logic [NUM_BODIES-1:0]  body_vld_reg, acc_vld_reg, hit_reg;

    // Body memory and accumulator memory, with registered reads.
    body_t                  body_mem [NUM_BODIES];
    acc_t                   acc_mem  [NUM_BODIES];
    logic [IDX_W-1:0]       body_ra, acc_ra, body_ra_reg;
    body_t                  body_rd_reg, body_q;
    acc_t                   acc_rd_reg, acc_q;
    logic                   body_rv_reg, acc_rv_reg;
    logic                   body_we, acc_we;
    logic [IDX_W-1:0]       body_wa, acc_wa;
    body_t                  body_wd;
    acc_t                   acc_wd;

    // Pair datapath.
    body_t                  bi_reg;
    logic [30:0]            ax_reg, ay_reg;
    logic                   sx_reg, sy_reg, axis_reg;
    logic [31:0]            mj_reg;
    logic [63:0]            prod_reg, d2_reg;
    logic [63:0]            d2_sum;
    logic [31:0]            d_reg, q_reg;
    logic [47:0]            dvx_reg, dvy_reg;
    logic signed [32:0]     dx, dy;

    // Square root and divider.
    logic [63:0]            sq_val_reg;
    logic [35:0]            sq_rem_reg, sq_rem_sh, sq_trial;
    logic [31:0]            sq_res_reg;
    logic [4:0]             sq_cnt_reg;
    logic [63:0]            dv_dvd_reg;
    logic [31:0]            dv_rem_reg;
    logic [32:0]            dv_t;
    logic [6:0]             dv_cnt_reg;
    div_op_t                dop_reg;

    // Output register.
    logic                   out_valid_reg, out_user_reg, out_last_reg;
    logic [135:0]           out_data_reg;

    logic                   in_fire, is_load;
    logic [1:0]             in_idx;
    body_t                  in_body;
    logic signed [ACC_W:0]  vx_sum, vy_sum;
    logic signed [31:0]     vx_new, vy_new;
    logic signed [31:0]     px_new, py_new;
    logic signed [ACC_W-1:0] dvx_ext, dvy_ext, ai_x, ai_y, aj_x, aj_y;
    logic                   out_free;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_load       = s_axis_tuser[0];
    assign in_idx        = s_axis_tdata[1:0];
    assign in_body.px    = s_axis_tdata[33:2];
    assign in_body.py    = s_axis_tdata[65:34];
    assign in_body.vx    = s_axis_tdata[97:66];
    assign in_body.vy    = s_axis_tdata[129:98];
    assign in_body.m     = s_axis_tdata[161:130];
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // Read views: a body never written reads as its scene value, an accumulator not written this tick as zero.
    assign body_q = body_rv_reg ? body_rd_reg : scene_body(body_ra_reg);
    assign acc_q  = acc_rv_reg ? acc_rd_reg : '0;

    // Read addresses follow the sequencer.
    always_comb
    begin
        body_ra = pi_reg;
        acc_ra  = pi_reg;
        case (state_reg)
            S_RDJ:   body_ra = pj_reg;
            S_ACCWI: acc_ra  = pj_reg;
            S_URD:
            begin
                body_ra = pb_reg;
                acc_ra  = pb_reg;
            end
            default:
            begin
                body_ra = pi_reg;
                acc_ra  = pi_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (body_we)
        begin
            body_mem[body_wa] <= body_wd;
        end
        body_rd_reg <= body_mem[body_ra];
        if (acc_we)
        begin
            acc_mem[acc_wa] <= acc_wd;
        end
        acc_rd_reg <= acc_mem[acc_ra];
    end

    // Pair geometry from the two bodies.
    assign dx     = 33'(body_q.px) - 33'(bi_reg.px);
    assign dy     = 33'(body_q.py) - 33'(bi_reg.py);
    assign d2_sum = d2_reg + prod_reg;

    // Square root step: two radicand bits per cycle.
    assign sq_rem_sh = {sq_rem_reg[33:0], sq_val_reg[63:62]};
    assign sq_trial  = {2'b00, sq_res_reg, 2'b01};

    // Divider step: one quotient bit per cycle.
    assign dv_t = {dv_rem_reg, dv_dvd_reg[63]};

    // Force accumulation for body i (+) and body j (-) along each axis.
    assign dvx_ext = ACC_W'(dvx_reg);
    assign dvy_ext = ACC_W'(dvy_reg);
    assign ai_x = acc_q.x + (sx_reg ? -dvx_ext : dvx_ext);
    assign ai_y = acc_q.y + (sy_reg ? -dvy_ext : dvy_ext);
    assign aj_x = acc_q.x + (sx_reg ? dvx_ext : -dvx_ext);
    assign aj_y = acc_q.y + (sy_reg ? dvy_ext : -dvy_ext);

    // Final update of one body.
    assign vx_sum = (ACC_W+1)'(body_q.vx) + (ACC_W+1)'(acc_q.x);
    assign vy_sum = (ACC_W+1)'(body_q.vy) + (ACC_W+1)'(acc_q.y);
    assign vx_new = sat_vel(vx_sum);
    assign vy_new = sat_vel(vy_sum);
    assign px_new = sat_pos(33'(body_q.px) + 33'(vx_new));
    assign py_new = sat_pos(33'(body_q.py) + 33'(vy_new));

    // Memory write ports.
    always_comb
    begin
        body_we = 1'b0;
        body_wa = pb_reg;
        body_wd = '0;
        acc_we  = 1'b0;
        acc_wa  = pi_reg;
        acc_wd  = '0;
        case (state_reg)
            S_IDLE:
            begin
                body_we = in_fire && is_load && (int'(in_idx) < NUM_BODIES);
                body_wa = IDX_W'(in_idx);
                body_wd = in_body;
            end
            S_ACCWI:
            begin
                acc_we   = 1'b1;
                acc_wa   = pi_reg;
                acc_wd.x = ai_x;
                acc_wd.y = ai_y;
            end
            S_ACCWJ:
            begin
                acc_we   = 1'b1;
                acc_wa   = pj_reg;
                acc_wd.x = aj_x;
                acc_wd.y = aj_y;
            end
            S_UWR:
            begin
                body_we    = 1'b1;
                body_wa    = pb_reg;
                body_wd.px = px_new;
                body_wd.py = py_new;
                body_wd.vx = vx_new;
                body_wd.vy = vy_new;
                body_wd.m  = body_q.m;
            end
            default:
            begin
                body_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_fire && !is_load) state_next = S_RDI;
            S_RDI:    state_next = S_RDJ;
            S_RDJ:    state_next = S_DIFF;
            S_DIFF:   state_next = S_SQX;
            S_SQX:    state_next = S_SQY;
            S_SQY:    state_next = S_D2;
            S_D2:     state_next = (d2_sum == '0) ? S_NEXT : S_SQRT;
            S_SQRT:   if (sq_cnt_reg == 5'd31) state_next = S_MM;
            S_MM:     state_next = S_GM;
            S_GM:     state_next = S_QST;
            S_QST:    state_next = S_DIV;
            S_DIV:    if (dv_cnt_reg == 7'd1) state_next = S_DIVEND;
            S_DIVEND:
            begin
                case (dop_reg)
                    DOP_Q:   state_next = S_MULA;
                    DOP_R:   state_next = S_DIV;
                    DOP_DV:  state_next = axis_reg ? S_ACCRI : S_MULA;
                    default: state_next = S_IDLE;
                endcase
            end
            S_MULA:   state_next = S_RST;
            S_RST:    state_next = S_DIV;
            S_ACCRI:  state_next = S_ACCWI;
            S_ACCWI:  state_next = S_ACCWJ;
            S_ACCWJ:  state_next = S_NEXT;
            S_NEXT:
            begin
                if (pj_reg == LAST_IDX && pi_reg == IDX_W'(NUM_BODIES - 2))
                begin
                    state_next = S_URD;
                end
                else
                begin
                    state_next = S_RDI;
                end
            end
            S_URD:    if (out_free) state_next = S_UWR;
            S_UWR:    state_next = (pb_reg == LAST_IDX) ? S_IDLE : S_URD;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            g_reg         <= G_RESET;
            body_vld_reg  <= '0;
            acc_vld_reg   <= '0;
            hit_reg       <= '0;
            pi_reg        <= '0;
            pj_reg        <= '0;
            pb_reg        <= '0;
            out_valid_reg <= 1'b0;
            sq_cnt_reg    <= '0;
            dv_cnt_reg    <= '0;
            dop_reg       <= DOP_Q;
            axis_reg      <= 1'b0;
            body_rv_reg   <= 1'b0;
            acc_rv_reg    <= 1'b0;
            body_ra_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            body_rv_reg <= body_vld_reg[body_ra];
            acc_rv_reg  <= acc_vld_reg[acc_ra];
            body_ra_reg <= body_ra;
            if (cfg_valid && cfg_ready)
            begin
                g_reg <= cfg_data;
            end
            if (body_we)
            begin
                body_vld_reg[body_wa] <= 1'b1;
            end
            if (acc_we)
            begin
                acc_vld_reg[acc_wa] <= 1'b1;
            end
            // The output word is loaded on a body write and cleared when taken.
            if (state_reg == S_UWR)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && !is_load)
                    begin
                        acc_vld_reg <= '0;
                        hit_reg     <= '0;
                        pi_reg      <= '0;
                        pj_reg      <= IDX_W'(1);
                        pb_reg      <= '0;
                    end
                end
                S_D2:
                begin
                    if (d2_sum == '0)
                    begin
                        hit_reg[pi_reg] <= 1'b1;
                        hit_reg[pj_reg] <= 1'b1;
                    end
                    sq_cnt_reg <= '0;
                end
                S_SQRT:   sq_cnt_reg <= sq_cnt_reg + 5'd1;
                S_QST:
                begin
                    dv_cnt_reg <= 7'd48;
                    dop_reg    <= DOP_Q;
                end
                S_DIV:    dv_cnt_reg <= dv_cnt_reg - 7'd1;
                S_DIVEND:
                begin
                    case (dop_reg)
                        DOP_Q:
                        begin
                            axis_reg <= 1'b0;
                        end
                        DOP_R:
                        begin
                            dv_cnt_reg <= 7'd48;
                            dop_reg    <= DOP_DV;
                        end
                        DOP_DV:
                        begin
                            axis_reg <= 1'b1;
                        end
                        default:
                        begin
                            axis_reg <= 1'b0;
                        end
                    endcase
                end
                S_RST:
                begin
                    dv_cnt_reg <= 7'd63;
                    dop_reg    <= DOP_R;
                end
                S_NEXT:
                begin
                    if (pj_reg == LAST_IDX)
                    begin
                        pi_reg <= pi_reg + IDX_W'(1);
                        pj_reg <= pi_reg + IDX_W'(2);
                    end
                    else
                    begin
                        pj_reg <= pj_reg + IDX_W'(1);
                    end
                end
                S_UWR:
                begin
                    pb_reg <= pb_reg + IDX_W'(1);
                end
                default:
                begin
                    axis_reg <= axis_reg;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_RDJ:    bi_reg <= body_q;
            S_DIFF:
            begin
                ax_reg <= mag31(dx);
                ay_reg <= mag31(dy);
                sx_reg <= dx[32];
                sy_reg <= dy[32];
                mj_reg <= body_q.m;
            end
            S_SQX:    prod_reg <= 64'(ax_reg) * 64'(ax_reg);
            S_SQY:
            begin
                d2_reg   <= prod_reg;
                prod_reg <= 64'(ay_reg) * 64'(ay_reg);
            end
            S_D2:
            begin
                sq_val_reg <= d2_sum;
                sq_rem_reg <= '0;
                sq_res_reg <= '0;
            end
            S_SQRT:
            begin
                sq_val_reg <= {sq_val_reg[61:0], 2'b00};
                if (sq_rem_sh >= sq_trial)
                begin
                    sq_rem_reg <= sq_rem_sh - sq_trial;
                    sq_res_reg <= {sq_res_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_rem_sh;
                    sq_res_reg <= {sq_res_reg[30:0], 1'b0};
                end
            end
            S_MM:
            begin
                d_reg    <= sq_res_reg;
                prod_reg <= 64'(bi_reg.m) * 64'(mj_reg);
            end
            S_GM:     prod_reg <= 64'(g_reg) * 64'(cap_q16(prod_reg));
            S_QST:
            begin
                dv_dvd_reg <= {cap_q16(prod_reg), 32'h0};
                dv_rem_reg <= '0;
            end
            S_DIV:
            begin
                if (dv_t >= {1'b0, d_reg})
                begin
                    dv_rem_reg <= 32'(dv_t - {1'b0, d_reg});
                    dv_dvd_reg <= {dv_dvd_reg[62:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg <= dv_t[31:0];
                    dv_dvd_reg <= {dv_dvd_reg[62:0], 1'b0};
                end
            end
            S_DIVEND:
            begin
                case (dop_reg)
                    DOP_Q:
                    begin
                        q_reg <= (|dv_dvd_reg[63:32]) ? 32'hFFFF_FFFF : dv_dvd_reg[31:0];
                    end
                    DOP_R:
                    begin
                        dv_dvd_reg <= {dv_dvd_reg[31:0], 32'h0};
                        dv_rem_reg <= '0;
                    end
                    DOP_DV:
                    begin
                        if (axis_reg)
                        begin
                            dvy_reg <= dv_dvd_reg[47:0];
                        end
                        else
                        begin
                            dvx_reg <= dv_dvd_reg[47:0];
                        end
                    end
                    default:
                    begin
                        dv_rem_reg <= '0;
                    end
                endcase
            end
            S_MULA:   prod_reg <= 64'(q_reg) * 64'(axis_reg ? ay_reg : ax_reg);
            S_RST:
            begin
                dv_dvd_reg <= {prod_reg[62:0], 1'b0};
                dv_rem_reg <= '0;
            end
            S_UWR:
            begin
                out_data_reg <= {6'h0, vy_new, vx_new, py_new, px_new, 2'(pb_reg)};
                out_user_reg <= hit_reg[pb_reg];
                out_last_reg <= (pb_reg == LAST_IDX);
            end
            default:
            begin
                d_reg <= d_reg;
            end
        endcase
    end

`include "three_body_gravity_step_unit_assert.svh"

    // The divider never runs on a zero distance.
    `TBG_ASSERT_NOW(a_div_nonzero, state_reg == S_DIV, d_reg != '0)
    // A result is only loaded into an empty output register.
    `TBG_ASSERT_NOW(a_out_free, state_reg == S_UWR, !out_valid_reg)
    // Pairs are always visited with the lower index first.
    `TBG_ASSERT_NOW(a_pair_order, state_reg == S_RDI, pi_reg < pj_reg)

endmodule

`default_nettype wire

FILE: test/tb_three_body_gravity_step_unit.sv
// Testbench of the three-body gravity step unit: directed and random load and tick words,
// checked against a predictor of the integrator. Depends on tbg_pkg and the unit's RTL.
`default_nettype none

module tb_three_body_gravity_step_unit
    import tbg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;
    localparam int   NB        = NUM_BODIES;
    localparam int   SETTLE    = 40;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint unsigned U32_CAP = 64'hFFFF_FFFF;

    // One body state word as it leaves the unit.
    typedef struct {
        logic [1:0]         idx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               coin;
        logic               last;
    } body_word_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    // Predictor copy of the bodies and of G.
    logic signed [31:0] st_px [NB];
    logic signed [31:0] st_py [NB];
    logic signed [31:0] st_vx [NB];
    logic signed [31:0] st_vy [NB];
    logic [31:0]        st_m  [NB];
    logic [31:0]        grav_g;

    body_word_t pending_bodies[$];
    int     err_count;
    longint cycle_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_left;

    three_body_gravity_step_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_three_body_gravity_step_unit: errors");
            $finish;
        end
    end

    // Integer square root, floor, digit by digit.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        rem  = v;
        res  = 0;
        bitv = 64'h1 << 62;
        while (bitv > rem)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned cap32(input longint unsigned v);
        return (v > U32_CAP) ? U32_CAP : v;
    endfunction

    function automatic longint unsigned clip_mag(input longint v);
        longint unsigned a;
        a = (v < 0) ? longint'(-v) : longint'(v);
        return (a > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : a;
    endfunction

    function automatic logic signed [31:0] clip_s32(input longint v);
        if (v > 64'sh7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Advance the predicted bodies by one step and queue the three expected words.
    task automatic predict_tick();
        longint acc_x [NB];
        longint acc_y [NB];
        logic   hit   [NB];
        longint dx;
        longint dy;
        longint unsigned ax, ay, d2, d, mm, gm, q, dvx, dvy;
        body_word_t w;
        for (int i = 0; i < NB; i++)
        begin
            acc_x[i] = 0;
            acc_y[i] = 0;
            hit[i]   = 1'b0;
        end
        for (int i = 0; i < NB; i++)
        begin
            for (int j = i + 1; j < NB; j++)
            begin
                dx = longint'(st_px[j]) - longint'(st_px[i]);
                dy = longint'(st_py[j]) - longint'(st_py[i]);
                ax = clip_mag(dx);
                ay = clip_mag(dy);
                d2 = ax * ax + ay * ay;
                if (d2 == 0)
                begin
                    hit[i] = 1'b1;
                    hit[j] = 1'b1;
                end
                else
                begin
                    d   = int_sqrt(d2);
                    mm  = cap32((longint'(st_m[i]) * longint'(st_m[j])) >> 16);
                    gm  = cap32((longint'(grav_g) * mm) >> 16);
                    q   = cap32((gm << 16) / d);
                    dvx = (((q * ax) / d) << 16) / d;
                    dvy = (((q * ay) / d) << 16) / d;
                    if (dx < 0)
                    begin
                        acc_x[i] -= longint'(dvx);
                        acc_x[j] += longint'(dvx);
                    end
                    else
                    begin
                        acc_x[i] += longint'(dvx);
                        acc_x[j] -= longint'(dvx);
                    end
                    if (dy < 0)
                    begin
                        acc_y[i] -= longint'(dvy);
                        acc_y[j] += longint'(dvy);
                    end
                    else
                    begin
                        acc_y[i] += longint'(dvy);
                        acc_y[j] -= longint'(dvy);
                    end
                end
            end
        end
        for (int i = 0; i < NB; i++)
        begin
            st_vx[i] = clip_s32(longint'(st_vx[i]) + acc_x[i]);
            st_vy[i] = clip_s32(longint'(st_vy[i]) + acc_y[i]);
            st_px[i] = clip_s32(longint'(st_px[i]) + longint'(st_vx[i]));
            st_py[i] = clip_s32(longint'(st_py[i]) + longint'(st_vy[i]));
            w.idx  = 2'(i);
            w.px   = st_px[i];
            w.py   = st_py[i];
            w.vx   = st_vx[i];
            w.vy   = st_vy[i];
            w.coin = hit[i];
            w.last = (i == NB - 1);
            pending_bodies.push_back(w);
        end
    endtask

    // Send one word and update the predictor when it is accepted.
    task automatic send_word(input logic mode, input logic [1:0] idx,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] m);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'd0, m, vy, vx, py, px, idx};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (mode == MODE_LOAD)
        begin
            if (idx < NB)
            begin
                st_px[idx] = px;
                st_py[idx] = py;
                st_vx[idx] = vx;
                st_vy[idx] = vy;
                st_m[idx]  = m;
            end
        end
        else
        begin
            predict_tick();
        end
        // Random gap before the next word.
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic send_tick();
        send_word(MODE_TICK, 2'($urandom()), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
    endtask

    task automatic send_load(input logic [1:0] idx, input int x, input int y,
                             input int vx, input int vy, input logic [31:0] m);
        send_word(MODE_LOAD, idx, x, y, vx, vy, m);
    endtask

    // Stop sending and wait until every expected body word has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_bodies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write G while the unit is idle.
    task automatic write_gravity(input logic [31:0] g);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        grav_g = g;
    endtask

    // Random coordinate: mostly within a screen-sized area, sometimes any value.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom();
        end
        return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16 | 32'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] rand_speed();
        if ($urandom_range(0, 5) == 0)
        begin
            return $urandom();
        end
        return 32'($signed($urandom_range(0, 262143)) - 131072);
    endfunction

    function automatic logic [31:0] rand_mass();
        if ($urandom_range(0, 5) == 0)
        begin
            return $urandom();
        end
        return 32'($urandom_range(0, 20 * 65536));
    endfunction

    // Mostly a fresh scene followed by ticks; sometimes lone loads and stray ticks.
    task automatic random_items(input int count);
        int sent;
        int ticks;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                for (int b = 0; b < NB; b++)
                begin
                    send_load(2'(b), rand_coord(), rand_coord(), rand_speed(), rand_speed(),
                              rand_mass());
                end
                ticks = $urandom_range(1, 4);
                for (int t = 0; t < ticks; t++)
                begin
                    send_tick();
                end
                sent += NB + ticks;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                send_word(MODE_LOAD, 2'($urandom()), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom());
                sent++;
            end
            else
            begin
                send_tick();
                sent++;
            end
        end
    endtask

    // Ticks from the default scene after reset.
    task automatic test_reset_scene();
        send_tick();
        send_tick();
    endtask

    // Coincident bodies, ignored loads, zero mass and saturation.
    task automatic test_special_cases();
        send_load(2'd0, 100 <<< 16, 100 <<< 16, 0, 0, 32'h0001_0000);
        send_load(2'd1, 100 <<< 16, 100 <<< 16, 0, 0, 32'h0003_0000);
        send_tick();
        send_load(2'd3, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_tick();
        send_load(2'd2, 100 <<< 16, 100 <<< 16, 5, -5, 32'h0000_0000);
        send_tick();
        send_load(2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'hFFFF_FFFF);
        send_load(2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF);
        send_load(2'd2, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_tick();
        send_tick();
        write_gravity(32'hFFFF_FFFF);
        send_load(2'd0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_load(2'd1, 1, 0, 0, 0, 32'hFFFF_FFFF);
        send_load(2'd2, 0, 1, 0, 0, 32'hFFFF_FFFF);
        send_tick();
        write_gravity(32'h0000_0000);
        send_tick();
    endtask

    // Random words over the idling phases, each with its own G.
    task automatic test_random_phases();
        int pct_send [4];
        int pct_recv [4];
        pct_send = '{0, 84, 0, 14};
        pct_recv = '{0, 0, 84, 14};
        for (int p = 0; p < 4; p++)
        begin
            write_gravity((p == 0) ? G_RESET : $urandom_range(0, 200 * 65536));
            send_idle_pct  = pct_send[p];
            recv_stall_pct = pct_recv[p];
            random_items(90);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Long output hold-off that backs up the input, then a pause until drained.
    task automatic test_backpressure();
        write_gravity(G_RESET);
        hold_left = 4000;
        for (int t = 0; t < 4; t++)
        begin
            send_tick();
        end
        wait_drained();
        random_items(20);
    endtask

    // Output ready with random stalls and an optional long hold-off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Compare each accepted body word with the oldest expectation.
    always @(posedge clk)
    begin
        body_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_bodies.size() == 0)
            begin
                $error("unexpected body word: out_index %0d", m_axis_tdata[1:0]);
                err_count++;
            end
            else
            begin
                w = pending_bodies.pop_front();
                if (m_axis_tdata[1:0] !== w.idx)
                begin
                    $error("out_index: expected %0d, got %0d", w.idx, m_axis_tdata[1:0]);
                    err_count++;
                end
                if (m_axis_tdata[33:2] !== w.px)
                begin
                    $error("out_pos_x: expected %h, got %h", w.px, m_axis_tdata[33:2]);
                    err_count++;
                end
                if (m_axis_tdata[65:34] !== w.py)
                begin
                    $error("out_pos_y: expected %h, got %h", w.py, m_axis_tdata[65:34]);
                    err_count++;
                end
                if (m_axis_tdata[97:66] !== w.vx)
                begin
                    $error("out_vel_x: expected %h, got %h", w.vx, m_axis_tdata[97:66]);
                    err_count++;
                end
                if (m_axis_tdata[129:98] !== w.vy)
                begin
                    $error("out_vel_y: expected %h, got %h", w.vy, m_axis_tdata[129:98]);
                    err_count++;
                end
                if (m_axis_tuser[0] !== w.coin)
                begin
                    $error("coincident: expected %b, got %b", w.coin, m_axis_tuser[0]);
                    err_count++;
                end
                if (m_axis_tlast !== w.last)
                begin
                    $error("last: expected %b, got %b", w.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = MODE_TICK;
        m_axis_tready  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        err_count      = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        grav_g         = G_RESET;
        for (int b = 0; b < NB; b++)
        begin
            {st_px[b], st_py[b], st_vx[b], st_vy[b], st_m[b]} = scene_body(2'(b));
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_scene();
        test_special_cases();
        test_random_phases();
        test_backpressure();
        wait_drained();

        if (err_count == 0 && pending_bodies.size() == 0)
        begin
            $display("tb_three_body_gravity_step_unit: clean");
        end
        else
        begin
            $display("tb_three_body_gravity_step_unit: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: three_body_gravity_step_unit.f
+incdir+hdl
hdl/tbg_pkg.sv
hdl/three_body_gravity_step_unit.sv
test/tb_three_body_gravity_step_unit.sv
